/* sv/ppdh_pkg.sv */
// Package with the transaction types and fixed constants of the pair distance histogram.
`timescale 1ns / 1ps
`default_nettype none
package ppdh_pkg;

  localparam int unsigned CfgW   = 18;
  localparam int unsigned PosW   = 32;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned FoldW  = 19;
  localparam int unsigned SqW    = 38;
  localparam int unsigned RootW  = 19;
  localparam int unsigned CountW = 32;
  localparam int unsigned IdxW   = 8;

  localparam logic [CfgW-1:0] BoxReset = 18'd25600;
  localparam logic [0:0] RegBoxWidth  = 1'b0;
  localparam logic [0:0] RegBoxHeight = 1'b1;
  localparam logic ModeAccum = 1'b0;
  localparam logic ModeRead  = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [PosW-1:0] x_a;
    logic [PosW-1:0] y_a;
    logic [PosW-1:0] x_b;
    logic [PosW-1:0] y_b;
    logic [IdxW-1:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   bin_index;
    logic [CountW-1:0] bin_count;
    logic              out_of_range;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic fold_fix;
    logic square;
    logic sum;
    logic sqrt_init;
    logic sqrt_step;
    logic bin_calc;
    logic mem_read;
    logic mem_write;
    logic clear_write;
    logic emit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic div_done;
    logic sqrt_done;
    logic clear_done;
  } stat_t;

endpackage
`default_nettype wire

/* sv/ppdh_datapath.sv */
// Datapath: periodic fold by restoring division, squares, square root, histogram memory.
`timescale 1ns / 1ps
`default_nettype none
module ppdh_datapath
  import ppdh_pkg::*;
#(
  parameter int unsigned NUM_BINS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ctrl_t           ctrl,
  output stat_t                stat,
  input  wire in_item_t        item,
  input  wire logic [CfgW-1:0] box_width,
  input  wire logic [CfgW-1:0] box_height,
  output out_item_t            result
);

  localparam int unsigned BinW = $clog2(NUM_BINS);
  localparam int unsigned DivCntW = 6;

  logic [CountW-1:0] hist [NUM_BINS];

  logic              is_read;
  logic [IdxW-1:0]   rbin;
  logic [CfgW-1:0]   lx;
  logic [CfgW-1:0]   ly;
  logic              neg_x;
  logic              neg_y;
  logic [DiffW-1:0]  dx;
  logic [DiffW-1:0]  dy;
  logic [CfgW-1:0]   rem_x;
  logic [CfgW-1:0]   rem_y;
  logic [DiffW-1:0]  quo_x;
  logic [DiffW-1:0]  quo_y;
  logic [DivCntW-1:0] div_cnt;
  logic [FoldW-1:0]  ax;
  logic [FoldW-1:0]  ay;
  logic [SqW-1:0]    sq_x;
  logic [SqW-1:0]    sq_y;
  logic [SqW:0]      s_val;
  logic [SqW:0]      s_rem;
  logic [SqW:0]      root;
  logic [SqW:0]      sbit;
  logic [RootW:0]    bin_val;
  logic              oor;
  logic [CountW-1:0] rd_data;
  logic [BinW-1:0]   clr_addr;
  logic              clr_done;

  // Restoring division step on a magnitude: shift in one quotient bit.
  function automatic logic [CfgW+DiffW-1:0] div_one(input logic [CfgW-1:0] r,
      input logic [DiffW-1:0] q, input logic [CfgW-1:0] l);
    logic [CfgW:0] t;
    logic [CfgW:0] d;
    logic [CfgW-1:0] rn;
    logic [DiffW-1:0] qn;
    t  = {r, q[DiffW-1]};
    d  = t - {1'b0, l};
    qn = {q[DiffW-2:0], ~d[CfgW]};
    rn = d[CfgW] ? t[CfgW-1:0] : d[CfgW-1:0];
    return {rn, qn};
  endfunction

  // Folds a magnitude remainder into the magnitude of the folded distance, nearest integer quotient with ties to even.
  function automatic logic [FoldW-1:0] fold_abs(input logic neg, input logic [CfgW-1:0] r,
      input logic q0, input logic [CfgW-1:0] l);
    logic [CfgW:0] r2;
    logic          up;
    logic [CfgW:0] rr;
    logic [CfgW:0] pos_r;
    logic [CfgW:0] lm;
    r2 = {r, 1'b0};
    lm = {1'b0, l};
    // For negative inputs the floor remainder is l - r (when r is nonzero), floor quotient is
    // -q-1, so parity flips; work out the rounding on that remainder.
    if (neg && (r != '0)) begin
      pos_r = lm - {1'b0, r};
      up = ({pos_r, 1'b0} > {1'b0, lm}) ||
           (({pos_r, 1'b0} == {1'b0, lm}) && !q0);
    end else begin
      pos_r = {1'b0, r};
      up = (r2 > lm) || ((r2 == lm) && q0);
    end
    rr = up ? (lm - pos_r) : pos_r;
    return rr[FoldW-1:0];
  endfunction

  // Rounds floor(2*distance) to the bin with ties to even; h is isqrt >> 7.
  function automatic logic [RootW:0] bin_calc_f(input logic [SqW:0] rt,
      input logic [SqW:0] s);
    logic [RootW:0] h;
    logic [RootW:0] k;
    logic [SqW:0]   hh;
    h  = (RootW+1)'(rt >> 7);
    k  = h >> 1;
    hh = (SqW+1)'(h * h);
    if (!h[0]) return k;
    if (s == (hh << 14)) return k[0] ? k + (RootW+1)'(1) : k;
    return k + (RootW+1)'(1);
  endfunction

  assign stat.is_read    = is_read;
  assign stat.div_done   = (div_cnt == DivCntW'(DiffW + 1));
  assign stat.sqrt_done  = (sbit == '0);
  assign stat.clear_done = clr_done;

  // Operand registers and the iterative division.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      is_read <= item.mode;
      rbin    <= item.read_bin;
      lx      <= (box_width == '0) ? CfgW'(1) : box_width;
      ly      <= (box_height == '0) ? CfgW'(1) : box_height;
      dx      <= DiffW'($signed(item.x_b)) - DiffW'($signed(item.x_a));
      dy      <= DiffW'($signed(item.y_b)) - DiffW'($signed(item.y_a));
      div_cnt <= '0;
      rem_x   <= '0;
      rem_y   <= '0;
    end else if (ctrl.div_step) begin
      if (div_cnt == '0) begin
        neg_x <= dx[DiffW-1];
        neg_y <= dy[DiffW-1];
        quo_x <= dx[DiffW-1] ? (~dx + DiffW'(1)) : dx;
        quo_y <= dy[DiffW-1] ? (~dy + DiffW'(1)) : dy;
        div_cnt <= div_cnt + DivCntW'(1);
      end else begin
        {rem_x, quo_x} <= div_one(rem_x, quo_x, lx);
        {rem_y, quo_y} <= div_one(rem_y, quo_y, ly);
        div_cnt <= div_cnt + DivCntW'(1);
      end
    end
    if (ctrl.fold_fix) begin
      ax <= fold_abs(neg_x, rem_x, quo_x[0], lx);
      ay <= fold_abs(neg_y, rem_y, quo_y[0], ly);
    end
    if (ctrl.square) begin
      sq_x <= SqW'(ax * ax);
      sq_y <= SqW'(ay * ay);
    end
    if (ctrl.sum) begin
      s_val <= {1'b0, sq_x} + {1'b0, sq_y};
    end
    // Bitwise square root, one result bit per step.
    if (ctrl.sqrt_init) begin
      s_rem <= s_val;
      root  <= '0;
      sbit  <= (SqW+1)'(1) << (SqW - 2);
    end else if (ctrl.sqrt_step) begin
      if (s_rem >= (root + sbit)) begin
        s_rem <= s_rem - (root + sbit);
        root  <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (ctrl.bin_calc) begin
      bin_val <= bin_calc_f(root, s_val);
    end
  end

  assign oor = is_read ? (32'(rbin) >= 32'(NUM_BINS)) : (32'(bin_val) >= 32'(NUM_BINS));

  // Histogram memory with a clearing pass after reset.
  always_ff @(posedge clk) begin
    if (ctrl.clear_write) begin
      hist[clr_addr] <= '0;
    end else if (ctrl.mem_write && !oor) begin
      hist[bin_val[BinW-1:0]] <= (rd_data > (CountW'('1) - CountW'(2))) ? CountW'('1) :
                                 rd_data + CountW'(2);
    end
    if (ctrl.mem_read) begin
      rd_data <= hist[is_read ? BinW'(rbin) : bin_val[BinW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else if (ctrl.clear_write) begin
      clr_addr <= clr_addr + BinW'(1);
      if (clr_addr == BinW'(NUM_BINS - 1)) clr_done <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      if (is_read) begin
        result.bin_index    <= rbin;
        result.bin_count    <= oor ? '0 : rd_data;
        result.out_of_range <= oor;
      end else if (oor) begin
        result <= '{bin_index: '0, bin_count: '0, out_of_range: 1'b1};
      end else begin
        result.bin_index    <= IdxW'(bin_val);
        result.bin_count    <= (rd_data > (CountW'('1) - CountW'(2))) ? CountW'('1) :
                               rd_data + CountW'(2);
        result.out_of_range <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ppdh_ctrl.sv */
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module ppdh_ctrl
  import ppdh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  output logic       done,
  output ctrl_t      ctrl,
  input  wire stat_t stat
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDecide= 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StFold  = 4'd4;
  localparam logic [3:0] StSq    = 4'd5;
  localparam logic [3:0] StSum   = 4'd6;
  localparam logic [3:0] StSqIn  = 4'd7;
  localparam logic [3:0] StSqrt  = 4'd8;
  localparam logic [3:0] StBin   = 4'd9;
  localparam logic [3:0] StRead  = 4'd10;
  localparam logic [3:0] StWrite = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.emit;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = (state != StIdle);
    case (state)
      StClear: begin
        if (stat.clear_done) state_next = StIdle;
        else ctrl.clear_write = 1'b1;
      end
      StIdle: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_next = StDecide;
        end
      end
      StDecide: state_next = stat.is_read ? StRead : StDiv;
      StDiv: begin
        ctrl.div_step = 1'b1;
        if (stat.div_done) begin
          ctrl.div_step = 1'b0;
          state_next = StFold;
        end
      end
      StFold: begin
        ctrl.fold_fix = 1'b1;
        state_next = StSq;
      end
      StSq: begin
        ctrl.square = 1'b1;
        state_next = StSum;
      end
      StSum: begin
        ctrl.sum = 1'b1;
        state_next = StSqIn;
      end
      StSqIn: begin
        ctrl.sqrt_init = 1'b1;
        state_next = StSqrt;
      end
      StSqrt: begin
        if (stat.sqrt_done) state_next = StBin;
        else ctrl.sqrt_step = 1'b1;
      end
      StBin: begin
        ctrl.bin_calc = 1'b1;
        state_next = StRead;
      end
      StRead: begin
        ctrl.mem_read = 1'b1;
        state_next = StWrite;
      end
      StWrite: begin
        ctrl.mem_write = !stat.is_read;
        ctrl.emit = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

endmodule
`default_nettype wire

/* sv/periodic_pair_distance_histogram.sv */
// Top level of the periodic pair distance histogram.
// One transaction is taken when start is high and busy is low; its result is on out_item
// with done high for exactly one cycle and cannot be stalled. A read transaction passes the
// decide, memory read and write states; an accumulate transaction also passes the division
// phase of restoring steps on the differences, the fold, square, sum and square root phases
// and the bin calculation. busy is low in the cycle in which done is high, so a new
// transaction can be taken in that cycle. After reset a clearing pass zeroes the histogram
// while busy is high.
// Box registers are written through cfg_write at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module periodic_pair_distance_histogram
  import ppdh_pkg::*;
#(
  parameter int unsigned NUM_BINS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire in_item_t        in_item,
  output logic                 done,
  output out_item_t            out_item,
  input  wire logic            cfg_write,
  input  wire logic [0:0]      cfg_index,
  input  wire logic [CfgW-1:0] cfg_data
);

  logic [CfgW-1:0] box_width;
  logic [CfgW-1:0] box_height;
  ctrl_t ctrl;
  stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= BoxReset;
      box_height <= BoxReset;
    end else if (cfg_write) begin
      if (cfg_index == RegBoxWidth) box_width <= cfg_data;
      else box_height <= cfg_data;
    end
  end

  ppdh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .ctrl (ctrl),
    .stat (stat)
  );

  ppdh_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .item      (in_item),
    .box_width (box_width),
    .box_height(box_height),
    .result    (out_item)
  );

endmodule
`default_nettype wire
